@@ hdl/hsv_to_rgb_converter_defines.svh @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_defines
// Assertion macros shared by the HSV to RGB converter modules.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication
`define HSV2RGB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv2rgb check failed");

// next-cycle implication
`define HSV2RGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsv2rgb check failed");

`endif

@@ hdl/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Widths, source codes, sector table and stage types of the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int HUE_BITS    = 16;
   localparam int UNIT_BITS   = 16;
   localparam int CHAN_BITS   = 8;

   localparam int SEC_W       = 3;
   localparam int VAL_W       = UNIT_BITS + 1;
   localparam int MIX_W       = HUE_BITS + 3;
   localparam int DMF_W       = HUE_BITS + 1;
   localparam int SF_W        = VAL_W + HUE_BITS;
   localparam int SDF_W       = VAL_W + DMF_W;
   localparam int XS_W        = UNIT_BITS + HUE_BITS + 2;
   localparam int FAC_W       = UNIT_BITS + HUE_BITS + 1;
   localparam int PROD_W      = VAL_W + FAC_W;
   localparam int TOTAL_SHIFT = 2 * UNIT_BITS + HUE_BITS;

   // which of p, q, t, v feeds a channel
   localparam logic [1:0] SRC_P = 2'd0;
   localparam logic [1:0] SRC_Q = 2'd1;
   localparam logic [1:0] SRC_T = 2'd2;
   localparam logic [1:0] SRC_V = 2'd3;

   typedef logic [1:0] src_type;

   typedef struct packed {
      logic [VAL_W-1:0] bri;
      logic [FAC_W-1:0] red_fac;
      logic [FAC_W-1:0] green_fac;
      logic [FAC_W-1:0] blue_fac;
   } factor_type;

   function automatic src_type red_src(input logic [SEC_W-1:0] sector);
      case (sector)
         3'd0:    return SRC_V;
         3'd1:    return SRC_Q;
         3'd2:    return SRC_P;
         3'd3:    return SRC_P;
         3'd4:    return SRC_T;
         default: return SRC_V;
      endcase
   endfunction

   function automatic src_type green_src(input logic [SEC_W-1:0] sector);
      case (sector)
         3'd0:    return SRC_T;
         3'd1:    return SRC_V;
         3'd2:    return SRC_V;
         3'd3:    return SRC_Q;
         3'd4:    return SRC_P;
         default: return SRC_P;
      endcase
   endfunction

   function automatic src_type blue_src(input logic [SEC_W-1:0] sector);
      case (sector)
         3'd0:    return SRC_P;
         3'd1:    return SRC_P;
         3'd2:    return SRC_T;
         3'd3:    return SRC_V;
         3'd4:    return SRC_V;
         default: return SRC_Q;
      endcase
   endfunction

endpackage

@@ hdl/hsv2rgb_factor.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_factor
// Three stages: hue split into sector and fraction, saturation products,
// then p/q/t formed, clamped at zero and routed to the three channels.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_factor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]    hue,
   input  logic [hsv2rgb_pkg::VAL_W-1:0]       saturation,
   input  logic [hsv2rgb_pkg::VAL_W-1:0]       brightness,
   output logic                                out_valid,
   input  logic                                out_stall,
   output hsv2rgb_pkg::factor_type             out_fac
);
   import hsv2rgb_pkg::*;

   localparam logic signed [XS_W-1:0] ONE_X  = XS_W'(1) << UNIT_BITS;
   localparam logic signed [XS_W-1:0] FULL_X = XS_W'(1) << (UNIT_BITS + HUE_BITS);
   localparam logic [DMF_W-1:0]       D_VAL  = DMF_W'(1) << HUE_BITS;

   logic en1, en2, en3;

   // stage 1
   logic                 s1_vld_ff;
   logic [SEC_W-1:0]     s1_sector_ff, s1_sector_in;
   logic [HUE_BITS-1:0]  s1_frac_ff, s1_frac_in;
   logic [DMF_W-1:0]     s1_dmf_ff, s1_dmf_in;
   logic [VAL_W-1:0]     s1_sat_ff, s1_bri_ff;
   logic [MIX_W-1:0]     six_h;

   // stage 2
   logic                 s2_vld_ff;
   logic [SEC_W-1:0]     s2_sector_ff;
   logic [VAL_W-1:0]     s2_sat_ff, s2_bri_ff;
   logic [SF_W-1:0]      s2_sf_ff, s2_sf_in;
   logic [SDF_W-1:0]     s2_sdf_ff, s2_sdf_in;

   // stage 3
   logic                 s3_vld_ff;
   factor_type           s3_fac_ff, s3_fac_in;
   logic signed [XS_W-1:0] xp, xq, xt;
   logic [FAC_W-1:0]     fp, fq, ft, fv;

   assign en3      = !s3_vld_ff || !out_stall;
   assign en2      = !s2_vld_ff || en3;
   assign en1      = !s1_vld_ff || en2;
   assign in_stall = !en1;

   function automatic logic [FAC_W-1:0] clamp_pos(input logic signed [XS_W-1:0] x);
      if (x <= 0) begin
         return '0;
      end
      return x[FAC_W-1:0];
   endfunction

   function automatic logic [FAC_W-1:0] pick(input src_type src,
                                             input logic [FAC_W-1:0] p,
                                             input logic [FAC_W-1:0] q,
                                             input logic [FAC_W-1:0] t,
                                             input logic [FAC_W-1:0] v);
      case (src)
         SRC_P:   return p;
         SRC_Q:   return q;
         SRC_T:   return t;
         default: return v;
      endcase
   endfunction

   // six times the hue by shift and add
   always_comb begin
      six_h        = (MIX_W'(hue) << 2) + (MIX_W'(hue) << 1);
      s1_sector_in = six_h[MIX_W-1:HUE_BITS];
      s1_frac_in   = six_h[HUE_BITS-1:0];
      s1_dmf_in    = D_VAL - DMF_W'(s1_frac_in);
   end

   always_comb begin
      s2_sf_in  = SF_W'(s1_sat_ff) * SF_W'(s1_frac_ff);
      s2_sdf_in = SDF_W'(s1_sat_ff) * SDF_W'(s1_dmf_ff);
   end

   always_comb begin
      xp = (ONE_X - $signed(XS_W'(s2_sat_ff))) <<< HUE_BITS;
      xq = FULL_X - $signed(XS_W'(s2_sf_ff));
      xt = FULL_X - $signed(XS_W'(s2_sdf_ff));
      fp = clamp_pos(xp);
      fq = clamp_pos(xq);
      ft = clamp_pos(xt);
      fv = FULL_X[FAC_W-1:0];
      s3_fac_in.bri       = s2_bri_ff;
      s3_fac_in.red_fac   = pick(red_src(s2_sector_ff), fp, fq, ft, fv);
      s3_fac_in.green_fac = pick(green_src(s2_sector_ff), fp, fq, ft, fv);
      s3_fac_in.blue_fac  = pick(blue_src(s2_sector_ff), fp, fq, ft, fv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_vld_ff <= in_valid;
         end
         if (en2) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (en3) begin
            s3_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_dmf_ff    <= s1_dmf_in;
         s1_sat_ff    <= saturation;
         s1_bri_ff    <= brightness;
      end
      if (en2) begin
         s2_sector_ff <= s1_sector_ff;
         s2_sat_ff    <= s1_sat_ff;
         s2_bri_ff    <= s1_bri_ff;
         s2_sf_ff     <= s2_sf_in;
         s2_sdf_ff    <= s2_sdf_in;
      end
      if (en3) begin
         s3_fac_ff <= s3_fac_in;
      end
   end

   assign out_valid = s3_vld_ff;
   assign out_fac   = s3_fac_ff;

   // input only blocked when every stage is full and the far side stalls
   `HSV2RGB_ASSERT_IMPL(a_stall_full, clock, reset, in_stall,
      s1_vld_ff && s2_vld_ff && s3_vld_ff && out_stall)
   // a stalled item at the output stays put
   `HSV2RGB_ASSERT_NEXT(a_fac_hold, clock, reset, s3_vld_ff && out_stall,
      s3_vld_ff && $stable(s3_fac_ff))

endmodule

@@ hdl/hsv2rgb_scale.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Two stages: brightness times channel factor, then scale by 255 with
// round half up and clamp into the output register.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_stall,
   input  hsv2rgb_pkg::factor_type             in_fac,
   output logic                                out_valid,
   input  logic                                out_stall,
   output logic [hsv2rgb_pkg::CHAN_BITS-1:0]   red,
   output logic [hsv2rgb_pkg::CHAN_BITS-1:0]   green,
   output logic [hsv2rgb_pkg::CHAN_BITS-1:0]   blue
);
   import hsv2rgb_pkg::*;

   localparam int ACC_W = TOTAL_SHIFT + CHAN_BITS;
   localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (TOTAL_SHIFT - 1);

   logic en4, en5;

   logic                 s4_vld_ff;
   logic [PROD_W-1:0]    s4_red_ff, s4_green_ff, s4_blue_ff;
   logic [PROD_W-1:0]    s4_red_in, s4_green_in, s4_blue_in;

   logic                 s5_vld_ff;
   logic [CHAN_BITS-1:0] s5_red_ff, s5_green_ff, s5_blue_ff;

   assign en5      = !s5_vld_ff || !out_stall;
   assign en4      = !s4_vld_ff || en5;
   assign in_stall = !en4;

   // floor(255 * n / 2^TOTAL_SHIFT + 1/2), saturating at one
   function automatic logic [CHAN_BITS-1:0] to_chan(input logic [PROD_W-1:0] n);
      logic [ACC_W-1:0] low;
      logic [ACC_W-1:0] acc;
      low = ACC_W'(n[TOTAL_SHIFT-1:0]);
      acc = (low << CHAN_BITS) - low + HALF;
      if (n[PROD_W-1:TOTAL_SHIFT] != '0) begin
         return '1;
      end
      return acc[ACC_W-1:TOTAL_SHIFT];
   endfunction

   always_comb begin
      s4_red_in   = PROD_W'(in_fac.bri) * PROD_W'(in_fac.red_fac);
      s4_green_in = PROD_W'(in_fac.bri) * PROD_W'(in_fac.green_fac);
      s4_blue_in  = PROD_W'(in_fac.bri) * PROD_W'(in_fac.blue_fac);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         if (en4) begin
            s4_vld_ff <= in_valid;
         end
         if (en5) begin
            s5_vld_ff <= s4_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_red_ff   <= s4_red_in;
         s4_green_ff <= s4_green_in;
         s4_blue_ff  <= s4_blue_in;
      end
      if (en5) begin
         s5_red_ff   <= to_chan(s4_red_ff);
         s5_green_ff <= to_chan(s4_green_ff);
         s5_blue_ff  <= to_chan(s4_blue_ff);
      end
   end

   assign out_valid = s5_vld_ff;
   assign red       = s5_red_ff;
   assign green     = s5_green_ff;
   assign blue      = s5_blue_ff;

   // a product held behind a stalled output is neither lost nor changed
   `HSV2RGB_ASSERT_NEXT(a_prod_hold, clock, reset, s4_vld_ff && !en5,
      s4_vld_ff && $stable(s4_red_ff) && $stable(s4_green_ff) && $stable(s4_blue_ff))

endmodule

@@ hdl/hsv_to_rgb_converter.sv @@
// HSV to RGB converter: takes one HSV pixel per clock while req_stall is low
// and returns 8-bit RGB. Hue is a 16-bit fraction of a turn, saturation and
// brightness carry 16 fraction bits (65536 is 1.0). A pixel passes through
// the pipeline stages (sector split, saturation products, factor select,
// brightness multiply, scale and round), and a new pixel may enter every
// cycle that req_stall is low. Each stage moves on its own valid bit, so a
// stall on rsp_ holds the last result in the output register while earlier
// stages keep filling; req_stall rises only once all five stages hold an
// item. There is no state to reset beyond the stage valid bits.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Top level: factor stages followed by scale stages.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]    req_hue,
   input  logic [hsv2rgb_pkg::VAL_W-1:0]       req_saturation,
   input  logic [hsv2rgb_pkg::VAL_W-1:0]       req_brightness,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hsv2rgb_pkg::CHAN_BITS-1:0]   rsp_red,
   output logic [hsv2rgb_pkg::CHAN_BITS-1:0]   rsp_green,
   output logic [hsv2rgb_pkg::CHAN_BITS-1:0]   rsp_blue
);
   import hsv2rgb_pkg::*;

   logic       fac_valid;
   logic       fac_stall;
   factor_type fac;

   hsv2rgb_factor u_factor (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (fac_valid),
      .out_stall  (fac_stall),
      .out_fac    (fac)
   );

   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fac_valid),
      .in_stall  (fac_stall),
      .in_fac    (fac),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

   // back-pressure on the input only comes from a stalled, full output
   `HSV2RGB_ASSERT_IMPL(a_req_stall_cause, clock, reset, req_stall,
      rsp_valid && rsp_stall && fac_valid)

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the HSV to RGB converter. Pixels go in on the req_ channel
// under random idling and back-pressure. Each accepted pixel is run through
// an exact fixed-point model of the sector table, and each returned pixel
// is checked channel by channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

   import hsv2rgb_pkg::*;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } pixel_rgb_type;

   localparam int UNIT_LEVEL   = 1 << UNIT_BITS;
   localparam int DRAIN_CYCLES = 12;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [HUE_BITS-1:0]    req_hue        = '0;
   logic [VAL_W-1:0]       req_saturation = '0;
   logic [VAL_W-1:0]       req_brightness = '0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [CHAN_BITS-1:0]   rsp_red;
   logic [CHAN_BITS-1:0]   rsp_green;
   logic [CHAN_BITS-1:0]   rsp_blue;

   pixel_rgb_type expected_rgb_q[$];
   int            mismatch_count = 0;
   bit            steady_flow    = 1'b0;

   hsv_to_rgb_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // numerator over 2^TOTAL_SHIFT to one rounded, clamped channel
   function automatic logic [CHAN_BITS-1:0] scale_channel(input longint num);
      longint k;
      k = longint'(1) << TOTAL_SHIFT;
      if (num <= 0)
         return '0;
      if (num >= k)
         return 8'd255;
      return CHAN_BITS'((longint'(255) * num + (k >> 1)) >> TOTAL_SHIFT);
   endfunction

   function automatic pixel_rgb_type predict_rgb(input logic [HUE_BITS-1:0] hue,
                                                 input logic [VAL_W-1:0]    sat,
                                                 input logic [VAL_W-1:0]    bri);
      longint        h, s, v, six_h, f, d, one, full;
      longint        nv, np, nq, nt, r, g, b;
      int            sector;
      pixel_rgb_type rgb;
      h      = longint'(hue);
      s      = longint'(sat);
      v      = longint'(bri);
      d      = longint'(1) << HUE_BITS;
      one    = longint'(1) << UNIT_BITS;
      full   = one * d;
      six_h  = h * 6;
      sector = int'(six_h >> HUE_BITS);
      f      = six_h & (d - 1);
      nv     = v * full;
      np     = v * ((one - s) * d);
      nq     = v * (full - s * f);
      nt     = v * (full - s * (d - f));
      case (sector)
         0:       begin r = nv; g = nt; b = np; end
         1:       begin r = nq; g = nv; b = np; end
         2:       begin r = np; g = nv; b = nt; end
         3:       begin r = np; g = nq; b = nv; end
         4:       begin r = nt; g = np; b = nv; end
         default: begin r = nv; g = np; b = nq; end
      endcase
      if (s == 0) begin
         r = nv;
         g = nv;
         b = nv;
      end
      rgb.red   = scale_channel(r);
      rgb.green = scale_channel(g);
      rgb.blue  = scale_channel(b);
      return rgb;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // back-pressure on the result side
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !steady_flow && ($urandom_range(99) < 34);
   end

   // prediction on each accepted item, check on each returned item
   always @(posedge clock) begin
      pixel_rgb_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb_q.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = expected_rgb_q.pop_front();
               if (rsp_red !== want.red)
                  report_mismatch("red", int'(rsp_red), int'(want.red));
               if (rsp_green !== want.green)
                  report_mismatch("green", int'(rsp_green), int'(want.green));
               if (rsp_blue !== want.blue)
                  report_mismatch("blue", int'(rsp_blue), int'(want.blue));
            end
         end
         if (req_valid && !req_stall)
            expected_rgb_q.push_back(predict_rgb(req_hue, req_saturation, req_brightness));
      end
   end

   task automatic send_pixel(input logic [HUE_BITS-1:0] hue,
                             input logic [VAL_W-1:0]    sat,
                             input logic [VAL_W-1:0]    bri);
      // idle cycles before the item, each taken at random
      while (!steady_flow && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         req_hue   <= HUE_BITS'($urandom);
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // in-range levels, with weight on zero, full scale, tiny and near-full values
   function automatic logic [VAL_W-1:0] pick_level();
      case ($urandom_range(9))
         0:       return '0;
         1:       return VAL_W'(UNIT_LEVEL);
         2:       return VAL_W'($urandom_range(3));
         3:       return VAL_W'(UNIT_LEVEL - $urandom_range(3));
         default: return VAL_W'($urandom_range(UNIT_LEVEL));
      endcase
   endfunction

   function automatic logic [HUE_BITS-1:0] pick_hue();
      int k;
      int edge_hue;
      if ($urandom_range(9) == 0) begin
         // near a sector boundary
         k        = $urandom_range(1, 5);
         edge_hue = (k * (1 << HUE_BITS) + 5) / 6;
         return HUE_BITS'(edge_hue + $urandom_range(4) - 2);
      end
      return HUE_BITS'($urandom);
   endfunction

   task automatic test_extremes();
      for (int i = 0; i < 8; i++)
         send_pixel(i[0] ? '1 : '0,
                    i[1] ? VAL_W'(UNIT_LEVEL) : '0,
                    i[2] ? VAL_W'(UNIT_LEVEL) : '0);
   endtask

   task automatic test_grey();
      send_pixel(HUE_BITS'(12345), '0, VAL_W'(UNIT_LEVEL / 2));
      send_pixel(HUE_BITS'(50000), '0, VAL_W'(1));
      send_pixel('1, '0, VAL_W'(UNIT_LEVEL - 1));
   endtask

   task automatic test_sector_edges();
      int edge_hue;
      for (int k = 1; k < 6; k++) begin
         edge_hue = (k * (1 << HUE_BITS) + 5) / 6;
         send_pixel(HUE_BITS'(edge_hue - 1), VAL_W'(UNIT_LEVEL), VAL_W'(UNIT_LEVEL));
         send_pixel(HUE_BITS'(edge_hue), VAL_W'(UNIT_LEVEL - 1), VAL_W'(UNIT_LEVEL - 7));
      end
   endtask

   task automatic test_random(input int count);
      repeat (count)
         send_pixel(pick_hue(), pick_level(), pick_level());
   endtask

   // back-to-back items with the result side never stalled
   task automatic test_full_rate(input int count);
      steady_flow = 1'b1;
      test_random(count);
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_grey();
      test_sector_edges();
      test_random(700);
      test_full_rate(300);
      test_random(530);
      req_valid <= 1'b0;
      // let the last accepted item reach the queue first
      @(posedge clock);
      while (expected_rgb_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rgb_q.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
